FILE: rtl/encoder_window_rpm_macros.svh
// Assertion macros for the encoder window speed block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ENCODER_WINDOW_RPM_MACROS_SVH
`define ENCODER_WINDOW_RPM_MACROS_SVH
`ifndef SYNTHESIS
`define EWR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("encoder_window_rpm: assertion failed");
`define EWR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder_window_rpm: assertion failed");
`else
`define EWR_ASSERT(label, clk, rst_n, prop)
`define EWR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ewr_pkg.sv
// Shared constants, types and widths of the encoder window speed block.
// Used by ewr_ring, ewr_div and encoder_window_rpm; depends on nothing.
`timescale 1ns / 1ps

package ewr_pkg;

    localparam int DEPTH    = 32;
    localparam int CHANNELS = 4;

    localparam int CH_W    = 2;
    localparam int ANGLE_W = 12;
    localparam int TS_W    = 48;
    localparam int RPM_W   = 32;
    localparam int MINS_W  = 6;

    localparam int CHI_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int TURN_COUNTS = 4096;
    localparam int HALF_TURN   = 2048;
    localparam int RPM_SCALE   = 234375;
    localparam int SCALE_W     = 18;

    localparam int D_W    = ANGLE_W + 2;
    localparam int TOT_W  = $clog2((DEPTH - 1) * HALF_TURN + 1) + 1;
    localparam int MAG_W  = TOT_W - 1;
    localparam int PROD_W = MAG_W + SCALE_W;
    localparam int SAT_W  = (PROD_W > RPM_W + 1) ? PROD_W : RPM_W + 1;
    localparam int STEP_W = $clog2(PROD_W + 1);

    localparam logic signed [D_W-1:0] D_HALF = D_W'(HALF_TURN);
    localparam logic signed [D_W-1:0] D_TURN = D_W'(TURN_COUNTS);

    localparam logic [MINS_W-1:0] MIN_SAMPLES_RST = MINS_W'(10);

    localparam logic signed [RPM_W-1:0] RPM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RPM_W-1:0] RPM_MIN = 32'sh8000_0000;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic [PTR_W-1:0] wp;
        logic             full;
    } t_ring_stat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: rtl/ewr_ring.sv
// Per-channel sample rings: angle and timestamp memories with write pointers and full flags.
// Depends on ewr_pkg.
`timescale 1ns / 1ps

module ewr_ring (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [ewr_pkg::CHI_W-1:0]   i_wr_ch,
    input  logic [ewr_pkg::ANGLE_W-1:0] i_wr_angle,
    input  logic [ewr_pkg::TS_W-1:0]    i_wr_time,
    input  logic [ewr_pkg::CHI_W-1:0]   i_stat_ch,
    output ewr_pkg::t_ring_stat         o_stat,
    input  logic                        i_rd_en,
    input  logic [ewr_pkg::CHI_W-1:0]   i_rd_ch,
    input  logic [ewr_pkg::PTR_W-1:0]   i_rd_slot,
    output logic [ewr_pkg::ANGLE_W-1:0] o_rd_angle,
    output logic [ewr_pkg::TS_W-1:0]    o_rd_time
);
    import ewr_pkg::*;

    logic [ANGLE_W-1:0] r_angle_mem [CHANNELS][DEPTH];
    logic [TS_W-1:0]    r_time_mem  [CHANNELS][DEPTH];
    logic [PTR_W-1:0]   r_wp        [CHANNELS];
    logic               r_full      [CHANNELS];

    logic [PTR_W-1:0] w_wp_cur;
    logic [PTR_W-1:0] w_wp_next;

    assign w_wp_cur  = r_wp[i_wr_ch];
    assign w_wp_next = (w_wp_cur == PTR_W'(DEPTH - 1)) ? '0 : w_wp_cur + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_wp[i]   <= '0;
                r_full[i] <= 1'b0;
            end
        end else if (i_wr_en) begin
            r_wp[i_wr_ch] <= w_wp_next;
            if (w_wp_next == '0) begin
                r_full[i_wr_ch] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_angle_mem[i_wr_ch][w_wp_cur] <= i_wr_angle;
            r_time_mem[i_wr_ch][w_wp_cur]  <= i_wr_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_angle <= r_angle_mem[i_rd_ch][i_rd_slot];
            o_rd_time  <= r_time_mem[i_rd_ch][i_rd_slot];
        end
    end

    assign o_stat.wp   = r_wp[i_stat_ch];
    assign o_stat.full = r_full[i_stat_ch];

endmodule

FILE: rtl/ewr_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
// Depends on ewr_pkg.
`timescale 1ns / 1ps

module ewr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ewr_pkg::PROD_W-1:0] i_dividend,
    input  logic [ewr_pkg::TS_W-1:0]   i_divisor,
    output ewr_pkg::t_div_stat         o_stat,
    output logic [ewr_pkg::PROD_W-1:0] o_quotient
);
    import ewr_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [PROD_W-1:0] r_quo;
    logic [TS_W-1:0]   r_rem;
    logic [TS_W-1:0]   r_dsr;

    logic [TS_W:0]   w_rem_sh;
    logic [TS_W+1:0] w_diff;
    logic            w_ge;

    assign w_rem_sh = {r_rem, r_quo[PROD_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dsr};
    assign w_ge     = !w_diff[TS_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[TS_W-1:0] : w_rem_sh[TS_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

FILE: rtl/encoder_window_rpm.sv
// Top level of the encoder window speed block: handshakes, query sequencer and result register.
// Depends on ewr_pkg, ewr_ring, ewr_div and encoder_window_rpm_macros.svh.
//
// Input channel (i_valid/o_ready): operation 0 stores a 12-bit angle with its 48-bit
// microsecond timestamp into the ring of the given channel; operation 1 asks for the speed.
// A sample transfer produces no result. A query walks the held samples
// from oldest to newest, one ring read per cycle, then runs one multiply and a restoring
// division of one quotient bit per cycle. The block accepts no new item while a query
// is in progress.
// Output channel (o_valid/i_ready): one result per query, rpm in 1/16 rpm saturated to
// 32 bits, and speed_valid. The result sits in an output register, so a sample or a new
// query is accepted while a result waits; a finished query holds until that register is free.
// Configuration channel (i_cfg_valid/o_cfg_ready) writes min_samples and is always ready.
// Synchronous reset empties all rings and sets min_samples to 10.
`timescale 1ns / 1ps
`include "encoder_window_rpm_macros.svh"

module encoder_window_rpm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_operation,
    input  logic [ewr_pkg::CH_W-1:0]         i_channel,
    input  logic [ewr_pkg::ANGLE_W-1:0]      i_angle,
    input  logic [ewr_pkg::TS_W-1:0]         i_timestamp,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [ewr_pkg::RPM_W-1:0] o_rpm,
    output logic                             o_speed_valid,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ewr_pkg::MINS_W-1:0]       i_cfg_data
);
    import ewr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_SPAN,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state                    r_state, n_state;
    logic [CHI_W-1:0]          r_ch, n_ch;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [PTR_W-1:0]          r_slot, n_slot;
    logic [CNT_W-1:0]          r_iss, n_iss;
    logic                      r_dv, n_dv;
    logic                      r_dfirst, n_dfirst;
    logic                      r_dlast, n_dlast;
    logic [ANGLE_W-1:0]        r_prev, n_prev;
    logic signed [TOT_W-1:0]   r_total, n_total;
    logic [TS_W-1:0]           r_t0, n_t0;
    logic [TS_W-1:0]           r_t1, n_t1;
    logic                      r_neg, n_neg;
    logic [MAG_W-1:0]          r_mag, n_mag;
    logic                      r_zero, n_zero;
    logic                      r_out_valid, n_out_valid;
    logic signed [RPM_W-1:0]   r_rpm, n_rpm;
    logic                      r_speed_valid, n_speed_valid;
    logic [MINS_W-1:0]         r_min_samples, n_min_samples;

    logic                    w_in_acc;
    logic                    w_ch_ok;
    logic [CHI_W-1:0]        w_ch_idx;
    t_ring_stat              w_ring_stat;
    logic [CNT_W-1:0]        w_count;
    logic [PTR_W-1:0]        w_start;
    logic                    w_too_few;
    logic                    w_rd_en;
    logic [ANGLE_W-1:0]      w_rd_angle;
    logic [TS_W-1:0]         w_rd_time;
    logic signed [D_W-1:0]   w_d_raw;
    logic signed [D_W-1:0]   w_d_wrap;
    logic signed [TOT_W-1:0] w_delta_ext;
    logic [TS_W-1:0]         w_span;
    logic [MAG_W-1:0]        w_abs;
    logic [PROD_W-1:0]       w_prod;
    logic                    w_div_start;
    t_div_stat               w_div_stat;
    logic [PROD_W-1:0]       w_quo;
    logic [SAT_W-1:0]        w_qext;
    logic                    w_ovf;
    logic [RPM_W-1:0]        w_qpos;
    logic signed [RPM_W-1:0] w_sat;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && o_ready;
    assign w_ch_ok     = (int'(i_channel) < CHANNELS);
    assign w_ch_idx    = CHI_W'(i_channel);

    assign w_count   = w_ring_stat.full ? CNT_W'(DEPTH) : CNT_W'(w_ring_stat.wp);
    assign w_start   = w_ring_stat.full ? w_ring_stat.wp : '0;
    assign w_too_few = (w_count < CNT_W'(2)) || (int'(w_count) < int'(r_min_samples));

    assign w_rd_en = (r_state == S_WALK) && (r_iss < r_count);

    ewr_ring u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_in_acc && (i_operation == OP_SAMPLE) && w_ch_ok),
        .i_wr_ch    (w_ch_idx),
        .i_wr_angle (i_angle),
        .i_wr_time  (i_timestamp),
        .i_stat_ch  (w_ch_idx),
        .o_stat     (w_ring_stat),
        .i_rd_en    (w_rd_en),
        .i_rd_ch    (r_ch),
        .i_rd_slot  (r_slot),
        .o_rd_angle (w_rd_angle),
        .o_rd_time  (w_rd_time)
    );

    always_comb begin
        w_d_raw = signed'({2'b00, w_rd_angle}) - signed'({2'b00, r_prev});
        if (w_d_raw > D_HALF) begin
            w_d_wrap = w_d_raw - D_TURN;
        end else if (w_d_raw < -D_HALF) begin
            w_d_wrap = w_d_raw + D_TURN;
        end else begin
            w_d_wrap = w_d_raw;
        end
    end

    assign w_delta_ext = TOT_W'(w_d_wrap);
    assign w_span      = r_t1 - r_t0;
    assign w_abs       = MAG_W'(r_total[TOT_W-1] ? -r_total : r_total);
    assign w_prod      = PROD_W'(r_mag) * PROD_W'(RPM_SCALE);
    assign w_div_start = (r_state == S_MUL);

    ewr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (w_span),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    assign w_qext = SAT_W'(w_quo);
    assign w_ovf  = |w_qext[SAT_W-1:RPM_W-1];
    assign w_qpos = {1'b0, w_qext[RPM_W-2:0]};

    always_comb begin
        if (w_ovf) begin
            w_sat = r_neg ? RPM_MIN : RPM_MAX;
        end else begin
            w_sat = r_neg ? signed'(-w_qpos) : signed'(w_qpos);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_ch          = r_ch;
        n_count       = r_count;
        n_slot        = r_slot;
        n_iss         = r_iss;
        n_dv          = w_rd_en;
        n_dfirst      = w_rd_en && (r_iss == '0);
        n_dlast       = w_rd_en && (r_iss == r_count - CNT_W'(1));
        n_prev        = r_prev;
        n_total       = r_total;
        n_t0          = r_t0;
        n_t1          = r_t1;
        n_neg         = r_neg;
        n_mag         = r_mag;
        n_zero        = r_zero;
        n_out_valid   = r_out_valid && !i_ready;
        n_rpm         = r_rpm;
        n_speed_valid = r_speed_valid;
        n_min_samples = i_cfg_valid ? i_cfg_data : r_min_samples;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_operation == OP_QUERY)) begin
                    n_ch = w_ch_idx;
                    if (!w_ch_ok || w_too_few) begin
                        n_zero  = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_zero  = 1'b0;
                        n_count = w_count;
                        n_slot  = w_start;
                        n_iss   = '0;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (w_rd_en) begin
                    n_slot = (r_slot == PTR_W'(DEPTH - 1)) ? '0 : r_slot + PTR_W'(1);
                    n_iss  = r_iss + CNT_W'(1);
                end
                if (r_dv) begin
                    if (r_dfirst) begin
                        n_total = '0;
                        n_t0    = w_rd_time;
                    end else begin
                        n_total = r_total + w_delta_ext;
                    end
                    n_prev = w_rd_angle;
                    if (r_dlast) begin
                        n_t1    = w_rd_time;
                        n_state = S_SPAN;
                    end
                end
            end
            S_SPAN: begin
                if (w_span == '0) begin
                    n_zero  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_neg   = r_total[TOT_W-1];
                    n_mag   = w_abs;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid   = 1'b1;
                    n_rpm         = r_zero ? '0 : w_sat;
                    n_speed_valid = !r_zero;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_iss         <= '0;
            r_count       <= '0;
            r_dv          <= 1'b0;
            r_dfirst      <= 1'b0;
            r_dlast       <= 1'b0;
            r_zero        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_min_samples <= MIN_SAMPLES_RST;
        end else begin
            r_state       <= n_state;
            r_ch          <= n_ch;
            r_count       <= n_count;
            r_slot        <= n_slot;
            r_iss         <= n_iss;
            r_dv          <= n_dv;
            r_dfirst      <= n_dfirst;
            r_dlast       <= n_dlast;
            r_prev        <= n_prev;
            r_total       <= n_total;
            r_t0          <= n_t0;
            r_t1          <= n_t1;
            r_neg         <= n_neg;
            r_mag         <= n_mag;
            r_zero        <= n_zero;
            r_out_valid   <= n_out_valid;
            r_rpm         <= n_rpm;
            r_speed_valid <= n_speed_valid;
            r_min_samples <= n_min_samples;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_rpm         = r_rpm;
    assign o_speed_valid = r_speed_valid;

    `EWR_ASSERT(a_data_only_in_walk, i_clk, i_rst_n, r_dv |-> (r_state == S_WALK))
    `EWR_ASSERT(a_issue_bound, i_clk, i_rst_n, (r_state == S_WALK) |-> (r_iss <= r_count))
    `EWR_ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, r_state == S_MUL, w_div_stat.busy)

endmodule

FILE: tb/encoder_window_rpm_checker.sv
// Checker for the encoder window speed block: watches the sample, result and setting channels.
// Keeps its own copy of the rings and of min_samples, predicts each query and compares results.
// Depends on ewr_pkg only.
`timescale 1ns / 1ps

module encoder_window_rpm_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic                             i_operation,
    input  logic [ewr_pkg::CH_W-1:0]         i_channel,
    input  logic [ewr_pkg::ANGLE_W-1:0]      i_angle,
    input  logic [ewr_pkg::TS_W-1:0]         i_timestamp,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic signed [ewr_pkg::RPM_W-1:0] i_rpm,
    input  logic                             i_speed_valid,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [ewr_pkg::MINS_W-1:0]       i_cfg_data,
    output int                               o_pending,
    output int                               o_errors,
    output int                               o_results,
    output int                               o_valid_speeds,
    output int                               o_saturated
);
    import ewr_pkg::*;

    typedef struct packed {
        logic signed [RPM_W-1:0] rpm;
        logic                    speed_valid;
    } t_speed_result;

    logic [ANGLE_W-1:0] angles [CHANNELS][DEPTH];
    logic [TS_W-1:0]    stamps [CHANNELS][DEPTH];
    int unsigned        write_ptr [CHANNELS];
    logic               ring_full [CHANNELS];
    logic [MINS_W-1:0]  min_samples;
    t_speed_result      expected_speeds [$];

    function automatic t_speed_result predict_speed(int unsigned ch);
        t_speed_result     r;
        int unsigned       held;
        int unsigned       first;
        int unsigned       a;
        int unsigned       b;
        longint            total;
        int                d;
        logic [TS_W-1:0]   span;
        longint unsigned   mag;
        longint unsigned   quot;
        r.rpm = '0;
        r.speed_valid = 1'b0;
        if (ch >= CHANNELS) begin
            return r;
        end
        held = ring_full[ch] ? DEPTH : write_ptr[ch];
        first = ring_full[ch] ? write_ptr[ch] : 0;
        if (held < 2 || held < min_samples) begin
            return r;
        end
        total = 0;
        for (int unsigned i = 0; i + 1 < held; i++) begin
            a = (first + i) % DEPTH;
            b = (first + i + 1) % DEPTH;
            d = int'(angles[ch][b]) - int'(angles[ch][a]);
            if (d > HALF_TURN) begin
                d = d - TURN_COUNTS;
            end else if (d < -HALF_TURN) begin
                d = d + TURN_COUNTS;
            end
            total = total + d;
        end
        span = stamps[ch][(first + held - 1) % DEPTH] - stamps[ch][first];
        if (span == '0) begin
            return r;
        end
        r.speed_valid = 1'b1;
        mag = (total < 0) ? longint'(-total) : longint'(total);
        quot = (mag * 64'(RPM_SCALE)) / 64'(span);
        if (total < 0) begin
            r.rpm = (quot >= 64'h8000_0000) ? RPM_MIN : RPM_W'(-longint'(quot));
        end else begin
            r.rpm = (quot > 64'h7FFF_FFFF) ? RPM_MAX : quot[RPM_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_speed_result want;
        int unsigned   slot;
        int unsigned   ch;
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                write_ptr[c] = 0;
                ring_full[c] = 1'b0;
            end
            min_samples = MIN_SAMPLES_RST;
            expected_speeds.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                min_samples = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_speeds.size() == 0) begin
                    o_errors++;
                    $error("unexpected result: rpm %0d, speed_valid %0b",
                           $signed(i_rpm), i_speed_valid);
                end else begin
                    want = expected_speeds.pop_front();
                    if (i_rpm !== want.rpm) begin
                        o_errors++;
                        $error("rpm: expected %0d, actual %0d", $signed(want.rpm), $signed(i_rpm));
                    end
                    if (i_speed_valid !== want.speed_valid) begin
                        o_errors++;
                        $error("speed_valid: expected %0b, actual %0b",
                               want.speed_valid, i_speed_valid);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                ch = i_channel;
                if (i_operation == OP_QUERY) begin
                    want = predict_speed(ch);
                    if (want.speed_valid) begin
                        o_valid_speeds++;
                        if (want.rpm == RPM_MAX || want.rpm == RPM_MIN) begin
                            o_saturated++;
                        end
                    end
                    expected_speeds = {expected_speeds, want};
                end else if (ch < CHANNELS) begin
                    slot = write_ptr[ch];
                    angles[ch][slot] = i_angle;
                    stamps[ch][slot] = i_timestamp;
                    write_ptr[ch] = (slot + 1) % DEPTH;
                    if (write_ptr[ch] == 0) begin
                        ring_full[ch] = 1'b1;
                    end
                end
            end
        end
        o_pending = expected_speeds.size();
    end

endmodule

FILE: tb/encoder_window_rpm_test.sv
// Testbench top for the encoder window speed block: clock, reset, sample and query traffic.
// Depends on ewr_pkg, encoder_window_rpm and encoder_window_rpm_checker.
`timescale 1ns / 1ps

module encoder_window_rpm_test;
    import ewr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 223;

    typedef enum logic [1:0] {
        MOTION_SLOW,
        MOTION_FWD,
        MOTION_REV,
        MOTION_ERRATIC
    } t_motion;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_valid       = 1'b0;
    logic                     i_operation   = OP_SAMPLE;
    logic [CH_W-1:0]          i_channel     = '0;
    logic [ANGLE_W-1:0]       i_angle       = '0;
    logic [TS_W-1:0]          i_timestamp   = '0;
    logic                     i_ready       = 1'b0;
    logic                     i_cfg_valid   = 1'b0;
    logic [MINS_W-1:0]        i_cfg_data    = '0;
    logic                     o_ready;
    logic                     o_valid;
    logic signed [RPM_W-1:0]  o_rpm;
    logic                     o_speed_valid;
    logic                     o_cfg_ready;

    int pending;
    int errors;
    int results;
    int valid_speeds;
    int saturated;
    int send_idle        = 0;
    int recv_stall       = 0;
    int idle_cycles      = 0;
    int items_sent       = 0;
    int settings_written = 0;

    logic [ANGLE_W-1:0] track_angle  [CHANNELS];
    logic [TS_W-1:0]    track_stamp  [CHANNELS];
    t_motion            track_motion [CHANNELS];
    logic [MINS_W-1:0]  phase_min    [PHASES];

    encoder_window_rpm uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_channel     (i_channel),
        .i_angle       (i_angle),
        .i_timestamp   (i_timestamp),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_rpm         (o_rpm),
        .o_speed_valid (o_speed_valid),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    encoder_window_rpm_checker speed_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_operation    (i_operation),
        .i_channel      (i_channel),
        .i_angle        (i_angle),
        .i_timestamp    (i_timestamp),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_rpm          (o_rpm),
        .i_speed_valid  (o_speed_valid),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_errors       (errors),
        .o_results      (results),
        .o_valid_speeds (valid_speeds),
        .o_saturated    (saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles.", WATCHDOG_LIMIT);
            $display("encoder_window_rpm_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic [CH_W-1:0] ch,
                             input logic [ANGLE_W-1:0] ang, input logic [TS_W-1:0] ts);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_channel   <= ch;
        i_angle     <= ang;
        i_timestamp <= ts;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic write_min_samples(input logic [MINS_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // Holds the sender off until every predicted result has been taken, then, if asked, for a settling tail.
    task automatic settle(input bit with_tail);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        if (with_tail) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic random_item();
        logic [CH_W-1:0] ch;
        int              roll;
        int              delta;
        int              step;
        ch = CH_W'($urandom_range(CHANNELS - 1));
        roll = $urandom_range(99);
        if (roll < 25) begin
            send_item(OP_QUERY, ch, ANGLE_W'($urandom()), TS_W'({$urandom(), $urandom()}));
        end else if (roll < 35) begin
            send_item(OP_SAMPLE, ch, ANGLE_W'($urandom()), TS_W'({$urandom(), $urandom()}));
        end else begin
            if ($urandom_range(99) < 4) begin
                track_motion[ch] = t_motion'($urandom_range(3));
            end
            case (track_motion[ch])
                MOTION_SLOW: begin
                    step  = $urandom_range(20000, 5000);
                    delta = int'($urandom_range(200)) - 100;
                end
                MOTION_FWD: begin
                    step  = ($urandom_range(9) == 0) ? 1 : 0;
                    delta = int'($urandom_range(2048, 1500));
                end
                MOTION_REV: begin
                    step  = ($urandom_range(9) == 0) ? 1 : 0;
                    delta = -int'($urandom_range(2048, 1500));
                end
                default: begin
                    step  = $urandom_range(1000);
                    delta = int'($urandom_range(4096)) - 2048;
                end
            endcase
            track_angle[ch] = track_angle[ch] + ANGLE_W'(delta);
            track_stamp[ch] = track_stamp[ch] + TS_W'(step);
            send_item(OP_SAMPLE, ch, track_angle[ch], track_stamp[ch]);
        end
    endtask

    initial begin
        int p;
        int n;
        phase_min = '{6'd2, 6'd32, 6'd10, 6'd63, 6'd0, 6'd5, 6'd31, 6'd3};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty ring and a single sample under the reset threshold.
        send_item(OP_QUERY, 2'd0, 12'd0, 48'd0);
        send_item(OP_SAMPLE, 2'd0, 12'd0, 48'd0);
        send_item(OP_QUERY, 2'd0, 12'd0, 48'd0);
        settle(1'b1);
        write_min_samples(6'd2);
        // Backward wrap across zero.
        send_item(OP_SAMPLE, 2'd0, 12'd4095, 48'd1);
        send_item(OP_QUERY, 2'd0, 12'd0, 48'd0);
        // Zero span, then exact half turns in both directions.
        send_item(OP_SAMPLE, 2'd1, 12'd0, 48'd100);
        send_item(OP_SAMPLE, 2'd1, 12'd2048, 48'd100);
        send_item(OP_QUERY, 2'd1, 12'd0, 48'd0);
        send_item(OP_SAMPLE, 2'd1, 12'd0, 48'd200);
        send_item(OP_QUERY, 2'd1, 12'd0, 48'd0);
        // Timestamp wrap and forward angle wrap.
        send_item(OP_SAMPLE, 2'd2, 12'd4095, 48'hFFFF_FFFF_FFFF);
        send_item(OP_SAMPLE, 2'd2, 12'd0, 48'd5);
        send_item(OP_QUERY, 2'd2, 12'hFFF, 48'hFFFF_FFFF_FFFF);
        // Largest possible span.
        send_item(OP_SAMPLE, 2'd3, 12'd0, 48'd0);
        send_item(OP_SAMPLE, 2'd3, 12'd2048, 48'hFFFF_FFFF_FFFF);
        send_item(OP_QUERY, 2'd3, 12'd0, 48'd0);

        for (int c = 0; c < CHANNELS; c++) begin
            track_angle[c]  = ANGLE_W'($urandom());
            track_stamp[c]  = '1 - TS_W'($urandom_range(500000));
            track_motion[c] = t_motion'($urandom_range(3));
        end

        for (p = 0; p < PHASES; p++) begin
            settle(1'b1);
            write_min_samples(phase_min[p]);
            case (p % 4)
                0: begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle  = 47;
                    recv_stall = 0;
                end
                2: begin
                    send_idle  = 0;
                    recv_stall = 47;
                end
                default: begin
                    send_idle  = 38;
                    recv_stall = 38;
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_item();
                if ($urandom_range(149) == 0) begin
                    settle(1'b0);
                end
            end
        end
        settle(1'b1);

        $display("Run: %0d input transfers, %0d speed results checked, %0d min_samples writes.",
                 items_sent, results, settings_written);
        $display("Run: %0d results with a valid speed, %0d of them saturated.",
                 valid_speeds, saturated);
        if (errors == 0) begin
            $display("encoder_window_rpm_test: PASS");
        end else begin
            $display("encoder_window_rpm_test: FAIL");
        end
        $finish;
    end

endmodule
